@@ hw/rtl/qrs_pkg.sv @@
// qrs_pkg: widths, codes and item types for the quadratic root solver
// no dependencies; imported by qrs_div and quadratic_root_solver_top
package qrs_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int TOL_W      = 16;

  // magnitude of a coefficient, products, radicand and root widths
  localparam int MAG_W    = DATA_WIDTH;
  localparam int PROD_W   = 2 * DATA_WIDTH;
  localparam int RAD_W    = 2 * DATA_WIDTH + 2;
  localparam int SQRT_W   = RAD_W / 2;
  localparam int D0_NUM_W = DATA_WIDTH + 2 * FRAC_BITS;
  localparam int QNUM_W   = DATA_WIDTH + 2 + FRAC_BITS;
  localparam int QDEN_W   = DATA_WIDTH + 1;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_INF  = 2'd3;

  typedef enum logic [2:0] {
    MODE_NONE,
    MODE_LIN,
    MODE_SQRT,
    MODE_CZERO,
    MODE_DISC1,
    MODE_DISC2
  } mode_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] coef_a;
    logic signed [DATA_WIDTH-1:0] coef_b;
    logic signed [DATA_WIDTH-1:0] coef_c;
  } in_t;

  typedef struct packed {
    logic [1:0]                   root_count;
    logic signed [DATA_WIDTH-1:0] root_first;
    logic signed [DATA_WIDTH-1:0] root_second;
    logic                         saturated;
  } out_t;

  // sign-magnitude coefficients and their zero tests
  typedef struct packed {
    logic             an;
    logic             bn;
    logic             cn;
    logic [MAG_W-1:0] ma;
    logic [MAG_W-1:0] mb;
    logic [MAG_W-1:0] mc;
    logic             za;
    logic             zb;
    logic             zc;
  } coef_t;

  // context carried through the first divider and the square root
  typedef struct packed {
    mode_t            mode;
    logic [1:0]       count;
    logic             an;
    logic             bn;
    logic             cn;
    logic [MAG_W-1:0] ma;
    logic [MAG_W-1:0] mb;
    logic [MAG_W-1:0] mc;
    logic [RAD_W-1:0] dmag;
  } ctx_t;

  // context carried through the root dividers
  typedef struct packed {
    logic [1:0]        count;
    logic              use1;
    logic              neg1;
    logic              sqrt_r;
    logic [SQRT_W-1:0] s;
  } post_t;

  typedef struct packed {
    logic use2;
    logic neg2;
  } side_b_t;

endpackage

@@ hw/rtl/qrs_div.sv @@
// qrs_div: pipelined restoring divider, one quotient bit per stage
// depends on qrs_pkg for default widths
module qrs_div import qrs_pkg::*; #(
  parameter int NUM_W  = D0_NUM_W,
  parameter int DEN_W  = MAG_W,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side,
  output logic              out_valid,
  output logic [NUM_W-1:0]  quot,
  output logic [SIDE_W-1:0] out_side
);

  logic              st_v    [NUM_W];
  logic [NUM_W-1:0]  st_nq   [NUM_W];
  logic [DEN_W-1:0]  st_rem  [NUM_W];
  logic [DEN_W-1:0]  st_den  [NUM_W];
  logic [SIDE_W-1:0] st_side [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic              p_v;
    logic [NUM_W-1:0]  p_nq;
    logic [DEN_W-1:0]  p_rem;
    logic [DEN_W-1:0]  p_den;
    logic [SIDE_W-1:0] p_side;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign p_v    = in_valid;
      assign p_nq   = num;
      assign p_rem  = '0;
      assign p_den  = den;
      assign p_side = side;
    end else begin : g_next
      assign p_v    = st_v[k-1];
      assign p_nq   = st_nq[k-1];
      assign p_rem  = st_rem[k-1];
      assign p_den  = st_den[k-1];
      assign p_side = st_side[k-1];
    end

    // numerator bits leave at the top, quotient bits enter at the bottom
    assign trial = {p_rem, p_nq[NUM_W-1]};
    assign diff  = trial - {1'b0, p_den};
    assign ge    = trial >= {1'b0, p_den};

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[k] <= 1'b0;
      end else if (en) begin
        st_v[k] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_nq[k]   <= {p_nq[NUM_W-2:0], ge};
        st_rem[k]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        st_den[k]  <= p_den;
        st_side[k] <= p_side;
      end
    end
  end

  assign out_valid = st_v[NUM_W-1];
  assign quot      = st_nq[NUM_W-1];
  assign out_side  = st_side[NUM_W-1];

endmodule

@@ hw/rtl/quadratic_root_solver_top.sv @@
// quadratic_root_solver_top: real roots of a*x^2 + b*x + c in signed Q16.16
// depends on qrs_pkg and qrs_div
//
// usage
//   in channel (in_valid / in_ready / in_item) takes one coefficient triple per item
//   out channel (out_valid / out_ready / out_item) gives root count, two roots and
//   a saturation flag per item, in input order
//   cfg channel (cfg_valid / cfg_ready / cfg_data) writes zero_tolerance; it is
//   always ready and is meant to be written while no item is in flight
// stages: stages 1 to 3, the 64-stage first divider, the 33-stage square root,
//   the operand register, the 50-stage root dividers and the output register
// throughput: one item per cycle unless stalled; stages are registers with valid bits
// stalls: while out_valid waits on out_ready the whole pipe holds; the first stage
//   still takes an item if it is empty, so nothing is lost or repeated
// reset: rst (synchronous) empties the pipe and sets zero_tolerance to 1
module quadratic_root_solver_top import qrs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [TOL_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_item
);

  localparam int REM_W = SQRT_W + 2;

  // tolerance register
  logic [TOL_W-1:0] tol;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      tol <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;

  // global advance: the pipe moves whenever the output register can be refilled
  logic adv;
  logic v1;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv || !v1;

  // stage 1: sign-magnitude split and zero tests
  coef_t in_c;
  coef_t c1;

  always_comb begin
    in_c.an = in_item.coef_a[DATA_WIDTH-1];
    in_c.bn = in_item.coef_b[DATA_WIDTH-1];
    in_c.cn = in_item.coef_c[DATA_WIDTH-1];
    in_c.ma = in_c.an ? MAG_W'(-in_item.coef_a) : MAG_W'(in_item.coef_a);
    in_c.mb = in_c.bn ? MAG_W'(-in_item.coef_b) : MAG_W'(in_item.coef_b);
    in_c.mc = in_c.cn ? MAG_W'(-in_item.coef_c) : MAG_W'(in_item.coef_c);
    in_c.za = in_c.ma <= MAG_W'(tol);
    in_c.zb = in_c.mb <= MAG_W'(tol);
    in_c.zc = in_c.mc <= MAG_W'(tol);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_ready) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      c1 <= in_c;
    end
  end

  // stage 2: b*b and a*c
  logic              v2;
  coef_t             c2;
  logic [PROD_W-1:0] bb2;
  logic [PROD_W-1:0] ac2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c2  <= c1;
      bb2 <= c1.mb * c1.mb;
      ac2 <= c1.ma * c1.mc;
    end
  end

  // stage 3: discriminant magnitude and sign
  logic             v3;
  coef_t            c3;
  logic [RAD_W-1:0] dmag3;
  logic             dneg3;
  logic [RAD_W-1:0] ac4;
  logic [RAD_W-1:0] bbx;
  logic [RAD_W-1:0] dmag_c;
  logic             dneg_c;

  always_comb begin
    ac4 = {ac2, 2'b00};
    bbx = RAD_W'(bb2);
    if (c2.an != c2.cn) begin
      dneg_c = 1'b0;
      dmag_c = bbx + ac4;
    end else if (bbx >= ac4) begin
      dneg_c = 1'b0;
      dmag_c = bbx - ac4;
    end else begin
      dneg_c = 1'b1;
      dmag_c = ac4 - bbx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c3    <= c2;
      dmag3 <= dmag_c;
      dneg3 <= dneg_c;
    end
  end

  // case selection, in the order linear, b zero with c negative, c zero, discriminant
  ctx_t                ctx_c;
  logic [RAD_W-1:0]    tol_fix;
  logic [D0_NUM_W-1:0] num0;

  assign tol_fix = RAD_W'({tol, {FRAC_BITS{1'b0}}});
  assign num0    = D0_NUM_W'({c3.mc, {(2 * FRAC_BITS){1'b0}}});

  always_comb begin
    ctx_c.an    = c3.an;
    ctx_c.bn    = c3.bn;
    ctx_c.cn    = c3.cn;
    ctx_c.ma    = c3.ma;
    ctx_c.mb    = c3.mb;
    ctx_c.mc    = c3.mc;
    ctx_c.dmag  = dmag3;
    ctx_c.mode  = MODE_NONE;
    ctx_c.count = CNT_NONE;
    if (c3.za) begin
      if (c3.zb) begin
        ctx_c.count = c3.zc ? CNT_INF : CNT_NONE;
      end else begin
        ctx_c.count = CNT_ONE;
        if (!c3.zc) begin
          ctx_c.mode = MODE_LIN;
        end
      end
    end else if (c3.zb && c3.cn) begin
      // a negative leaves no real root
      if (!c3.an) begin
        ctx_c.count = CNT_TWO;
        ctx_c.mode  = MODE_SQRT;
      end
    end else if (c3.zc) begin
      if (c3.zb) begin
        ctx_c.count = CNT_ONE;
      end else begin
        ctx_c.count = CNT_TWO;
        ctx_c.mode  = MODE_CZERO;
      end
    end else if (!dneg3 && dmag3 != '0) begin
      ctx_c.count = CNT_TWO;
      ctx_c.mode  = MODE_DISC2;
    end else if (dmag3 <= tol_fix) begin
      ctx_c.count = CNT_ONE;
      ctx_c.mode  = MODE_DISC1;
    end
  end

  // first divider: c * 2^(2f) / a, only used when b is near zero
  logic                d0_valid;
  logic [D0_NUM_W-1:0] d0_quot;
  logic [$bits(ctx_t)-1:0] d0_side;
  ctx_t                d0_ctx;

  qrs_div #(
    .NUM_W  (D0_NUM_W),
    .DEN_W  (MAG_W),
    .SIDE_W ($bits(ctx_t))
  ) u_div0 (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v3),
    .num       (num0),
    .den       (c3.ma),
    .side      (ctx_c),
    .out_valid (d0_valid),
    .quot      (d0_quot),
    .out_side  (d0_side)
  );

  assign d0_ctx = ctx_t'(d0_side);

  // square root: one result bit per stage
  logic              sq_v    [SQRT_W];
  logic [RAD_W-1:0]  sq_rad  [SQRT_W];
  logic [REM_W-1:0]  sq_rem  [SQRT_W];
  logic [SQRT_W-1:0] sq_root [SQRT_W];
  ctx_t              sq_ctx  [SQRT_W];
  logic [RAD_W-1:0]  rad0;

  assign rad0 = (d0_ctx.mode == MODE_SQRT) ? RAD_W'(d0_quot) : d0_ctx.dmag;

  for (genvar k = 0; k < SQRT_W; k++) begin : g_sqrt
    logic              p_v;
    logic [RAD_W-1:0]  p_rad;
    logic [REM_W-1:0]  p_rem;
    logic [SQRT_W-1:0] p_root;
    ctx_t              p_ctx;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign p_v    = d0_valid;
      assign p_rad  = rad0;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_ctx  = d0_ctx;
    end else begin : g_next
      assign p_v    = sq_v[k-1];
      assign p_rad  = sq_rad[k-1];
      assign p_rem  = sq_rem[k-1];
      assign p_root = sq_root[k-1];
      assign p_ctx  = sq_ctx[k-1];
    end

    assign rem_sh = {p_rem[REM_W-3:0], p_rad[RAD_W-1 -: 2]};
    assign trial  = {p_root, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k] <= 1'b0;
      end else if (adv) begin
        sq_v[k] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rad[k]  <= {p_rad[RAD_W-3:0], 2'b00};
        sq_rem[k]  <= ge ? rem_sh - trial : rem_sh;
        sq_root[k] <= {p_root[SQRT_W-2:0], ge};
        sq_ctx[k]  <= p_ctx;
      end
    end
  end

  // operand preparation for the root dividers
  ctx_t              sc;
  logic [SQRT_W-1:0] s;
  logic [SQRT_W:0]   sx;
  logic [SQRT_W:0]   mbx;
  logic [SQRT_W:0]   sum_sm;
  logic [SQRT_W:0]   dif_sm;
  logic              s_ge;
  logic              mb_ge;
  logic              n1;
  logic              n2;
  logic [SQRT_W:0]   m1;
  logic [SQRT_W:0]   m2;
  logic [QDEN_W-1:0] den2a;
  logic [QNUM_W-1:0] num_a_c;
  logic [QNUM_W-1:0] num_b_c;
  logic [QDEN_W-1:0] den_a_c;
  logic [QDEN_W-1:0] den_b_c;
  post_t             pa_c;
  side_b_t           pb_c;

  assign sc     = sq_ctx[SQRT_W-1];
  assign s      = sq_root[SQRT_W-1];
  assign sx     = (SQRT_W + 1)'(s);
  assign mbx    = (SQRT_W + 1)'(sc.mb);
  assign sum_sm = sx + mbx;
  assign s_ge   = sx >= mbx;
  assign mb_ge  = mbx >= sx;
  assign dif_sm = s_ge ? sx - mbx : mbx - sx;
  assign den2a  = {sc.ma, 1'b0};

  always_comb begin
    // (-b + s) and (-b - s) in sign-magnitude form
    if (sc.bn) begin
      n1 = 1'b0;
      m1 = sum_sm;
      n2 = !mb_ge;
      m2 = dif_sm;
    end else begin
      n1 = !s_ge;
      m1 = dif_sm;
      n2 = 1'b1;
      m2 = sum_sm;
    end

    num_a_c     = '0;
    num_b_c     = '0;
    den_a_c     = den2a;
    den_b_c     = den2a;
    pa_c.count  = sc.count;
    pa_c.use1   = 1'b0;
    pa_c.neg1   = 1'b0;
    pa_c.sqrt_r = 1'b0;
    pa_c.s      = s;
    pb_c.use2   = 1'b0;
    pb_c.neg2   = 1'b0;

    case (sc.mode)
      MODE_LIN: begin
        num_a_c   = QNUM_W'({sc.mc, {FRAC_BITS{1'b0}}});
        den_a_c   = QDEN_W'(sc.mb);
        pa_c.use1 = 1'b1;
        pa_c.neg1 = sc.cn == sc.bn;
      end
      MODE_SQRT: begin
        pa_c.sqrt_r = 1'b1;
      end
      MODE_CZERO: begin
        num_b_c   = QNUM_W'({sc.mb, {FRAC_BITS{1'b0}}});
        den_b_c   = QDEN_W'(sc.ma);
        pb_c.use2 = 1'b1;
        pb_c.neg2 = sc.bn == sc.an;
      end
      MODE_DISC1: begin
        num_a_c   = QNUM_W'({sc.mb, {FRAC_BITS{1'b0}}});
        pa_c.use1 = 1'b1;
        pa_c.neg1 = sc.bn == sc.an;
      end
      MODE_DISC2: begin
        num_a_c   = QNUM_W'({m1, {FRAC_BITS{1'b0}}});
        num_b_c   = QNUM_W'({m2, {FRAC_BITS{1'b0}}});
        pa_c.use1 = 1'b1;
        pa_c.neg1 = n1 != sc.an;
        pb_c.use2 = 1'b1;
        pb_c.neg2 = n2 != sc.an;
      end
      default: begin
      end
    endcase
  end

  logic              vp;
  logic [QNUM_W-1:0] num_a_r;
  logic [QNUM_W-1:0] num_b_r;
  logic [QDEN_W-1:0] den_a_r;
  logic [QDEN_W-1:0] den_b_r;
  post_t             pa_r;
  side_b_t           pb_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (adv) begin
      vp <= sq_v[SQRT_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_a_r <= num_a_c;
      num_b_r <= num_b_c;
      den_a_r <= den_a_c;
      den_b_r <= den_b_c;
      pa_r    <= pa_c;
      pb_r    <= pb_c;
    end
  end

  // root dividers, run in lockstep; the first carries the item context
  logic                     va;
  logic                     vb;
  logic [QNUM_W-1:0]        qa;
  logic [QNUM_W-1:0]        qb;
  logic [$bits(post_t)-1:0] pa_side;
  logic [$bits(side_b_t)-1:0] pb_side;
  post_t                    pa_o;
  side_b_t                  pb_o;

  qrs_div #(
    .NUM_W  (QNUM_W),
    .DEN_W  (QDEN_W),
    .SIDE_W ($bits(post_t))
  ) u_div_a (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (vp),
    .num       (num_a_r),
    .den       (den_a_r),
    .side      (pa_r),
    .out_valid (va),
    .quot      (qa),
    .out_side  (pa_side)
  );

  qrs_div #(
    .NUM_W  (QNUM_W),
    .DEN_W  (QDEN_W),
    .SIDE_W ($bits(side_b_t))
  ) u_div_b (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (vp),
    .num       (num_b_r),
    .den       (den_b_r),
    .side      (pb_r),
    .out_valid (vb),
    .quot      (qb),
    .out_side  (pb_side)
  );

  assign pa_o = post_t'(pa_side);
  assign pb_o = side_b_t'(pb_side);

  // clamp a sign-magnitude root into the signed range, flag in the top bit
  function automatic logic [DATA_WIDTH:0] clamp_root(input logic neg,
                                                     input logic [QNUM_W-1:0] mag);
    logic [QNUM_W-1:0]     lim;
    logic [DATA_WIDTH-1:0] m;
    logic                  sat;
    lim = QNUM_W'(1) << (DATA_WIDTH - 1);
    if (!neg) begin
      lim = lim - QNUM_W'(1);
    end
    sat = mag > lim;
    m   = sat ? lim[DATA_WIDTH-1:0] : mag[DATA_WIDTH-1:0];
    return {sat, neg ? -m : m};
  endfunction

  logic [DATA_WIDTH:0]   cl1;
  logic [DATA_WIDTH:0]   cl2;
  logic [DATA_WIDTH-1:0] r1;
  logic [DATA_WIDTH-1:0] r2;
  logic                  sat1;
  logic                  sat2;

  always_comb begin
    r1   = '0;
    r2   = '0;
    sat1 = 1'b0;
    sat2 = 1'b0;
    cl1  = clamp_root(pa_o.neg1, qa);
    cl2  = clamp_root(pb_o.neg2, qb);
    if (pa_o.use1) begin
      {sat1, r1} = cl1;
    end else if (pa_o.sqrt_r) begin
      // roots are +r and its exact negation
      {sat1, r1} = clamp_root(1'b0, QNUM_W'(pa_o.s));
      r2         = -r1;
    end
    if (pb_o.use2) begin
      {sat2, r2} = cl2;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item.root_count  <= pa_o.count;
      out_item.root_first  <= r1;
      out_item.root_second <= r2;
      out_item.saturated   <= sat1 || sat2;
    end
  end

  // checks
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst) va == vb)
    else $error("root dividers out of step");

  a_inf_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.root_count == CNT_INF |->
      out_item.root_first == '0 && out_item.root_second == '0 && !out_item.saturated)
    else $error("infinite-root item carries roots");

  a_sat_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.saturated |->
      out_item.root_count == CNT_ONE || out_item.root_count == CNT_TWO)
    else $error("saturation without a root");

  a_ready: assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input blocked with empty output");

endmodule
